// ===== hdl/assert_macros.svh =====
// assertion macros used by the top level of the despeckle filter
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: ante implies cons");
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed: invariant violated");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

// ===== hdl/despk_pkg.sv =====
// shared types, constants and functions of the impulse despeckle filter
// no dependencies
`timescale 1ns / 1ps

package despk_pkg;

	localparam int MAX_WIDTH = 32;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WCFG_W    = 6;
	localparam int ROW_W     = 10;
	localparam int LVL_W     = 4;
	localparam int THR_W     = 4;
	localparam int GLYPH_W   = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 10;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 32;
	// queue depth must be a power of two
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);

	localparam logic [LVL_W-1:0] MAX_LEVEL = 4'd9;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = 6'd30;
	localparam logic [ROW_W-1:0]  HEIGHT_RESET = 10'd20;
	localparam logic [THR_W-1:0]  THRESH_RESET = 4'd1;

	// neighbor slots of the despeckle mask
	localparam int NB_UP    = 0;
	localparam int NB_DOWN  = 1;
	localparam int NB_LEFT  = 2;
	localparam int NB_RIGHT = 3;

	typedef struct packed {
		logic [LVL_W-1:0] lvl;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             emit;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_FREAD,
		B_FEXEC
	} back_state_t;

	function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] l);
		return (l > MAX_LEVEL) ? MAX_LEVEL : l;
	endfunction

	function automatic logic [WCFG_W-1:0] clamp_width(input logic [WCFG_W-1:0] w);
		logic [WCFG_W-1:0] r;
		r = w;
		if (w < WCFG_W'(2))
			r = WCFG_W'(2);
		else if (w > WCFG_W'(MAX_WIDTH))
			r = WCFG_W'(MAX_WIDTH);
		return r;
	endfunction

	function automatic logic [ROW_W-1:0] clamp_height(input logic [ROW_W-1:0] h);
		return (h < ROW_W'(2)) ? ROW_W'(2) : h;
	endfunction

	function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LVL_W-1:0] l);
		logic [GLYPH_W-1:0] g;
		case (l)
			4'd0:    g = 7'd32;
			4'd1:    g = 7'd46;
			4'd2:    g = 7'd39;
			4'd3:    g = 7'd58;
			4'd4:    g = 7'd126;
			4'd5:    g = 7'd42;
			4'd6:    g = 7'd61;
			4'd7:    g = 7'd34;
			4'd8:    g = 7'd37;
			default: g = 7'd35;
		endcase
		return g;
	endfunction

	// floored mean of the present neighbors when the center differs from all of them by more than the threshold
	function automatic logic [LVL_W-1:0] despeckle(
		input logic [LVL_W-1:0] center,
		input logic [LVL_W-1:0] up,
		input logic [LVL_W-1:0] down,
		input logic [LVL_W-1:0] left,
		input logic [LVL_W-1:0] right,
		input logic [3:0]       has,
		input logic [THR_W-1:0] thr
	);
		logic [LVL_W-1:0] nb [0:3];
		logic [5:0]       sum;
		logic [2:0]       cnt;
		logic             repl;
		logic [LVL_W-1:0] d;
		logic [9:0]       prod;
		logic [LVL_W-1:0] res;
		nb[NB_UP]    = up;
		nb[NB_DOWN]  = down;
		nb[NB_LEFT]  = left;
		nb[NB_RIGHT] = right;
		sum  = '0;
		cnt  = '0;
		repl = 1'b1;
		prod = '0;
		for (int k = 0; k < 4; k++) begin
			if (has[k]) begin
				cnt = cnt + 3'd1;
				sum = sum + {2'b00, nb[k]};
				d = (center > nb[k]) ? (center - nb[k]) : (nb[k] - center);
				if (d <= thr)
					repl = 1'b0;
			end
		end
		case (cnt)
			3'd1: res = sum[3:0];
			3'd2: res = sum[4:1];
			3'd3: begin
				// divide by three through 11/32, exact for sums up to 27
				prod = {4'b0000, sum} * 10'd11;
				res  = prod[8:5];
			end
			3'd4: res = sum[5:2];
			default: res = center;
		endcase
		if (!repl)
			res = center;
		return sat_level(res);
	endfunction

endpackage

// ===== hdl/despk_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module despk_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== hdl/despk_front.sv =====
// front end: accepts pixels, tracks raster position and classifies each pixel
// depends on despk_pkg
`timescale 1ns / 1ps

module despk_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [despk_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [despk_pkg::WCFG_W-1:0]         width,
	input  logic [despk_pkg::ROW_W-1:0]          height,
	input  despk_pkg::q_stat_t                   q_stat,
	output logic                                 push,
	output despk_pkg::cmd_t                      cmd
);
	import despk_pkg::*;

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic              wrap;
	logic [COL_W-1:0]  c;
	logic [ROW_W-1:0]  r0;
	logic [ROW_W-1:0]  r;
	logic              last;
	logic [WCFG_W-1:0] c_inc;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;

	// a width lowered mid-frame ends the row at once
	assign wrap  = {1'b0, col_q} >= width;
	assign c     = wrap ? '0 : col_q;
	assign r0    = wrap ? (row_q + ROW_W'(1)) : row_q;
	assign r     = (r0 >= height) ? (height - ROW_W'(1)) : r0;
	assign last  = (r == height - ROW_W'(1)) && ({1'b0, c} == width - WCFG_W'(1));
	assign c_inc = {1'b0, c} + WCFG_W'(1);

	always_comb begin
		cmd.lvl  = sat_level(s_tdata[LVL_W-1:0]);
		cmd.row  = r;
		cmd.col  = c;
		cmd.emit = (r != '0);
		cmd.last = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (c_inc >= width) begin
				col_q <= '0;
				row_q <= r + ROW_W'(1);
			end else begin
				col_q <= c_inc[COL_W-1:0];
				row_q <= r;
			end
		end
	end

endmodule

// ===== hdl/despk_queue.sv =====
// short command queue between the front end and the back end
// depends on despk_pkg
`timescale 1ns / 1ps

module despk_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  despk_pkg::cmd_t        push_cmd,
	input  logic                   pop,
	output despk_pkg::cmd_t        head_cmd,
	output despk_pkg::q_stat_t     stat,
	output logic [despk_pkg::QPTR_W:0] count
);
	import despk_pkg::*;

	cmd_t              mem_q [0:QDEPTH-1];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign head_cmd   = mem_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign count      = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

endmodule

// ===== hdl/despk_back.sv =====
// back end: line buffers, neighbor filter, last-row flush and output register
// depends on despk_pkg and despk_ram
`timescale 1ns / 1ps

module despk_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [despk_pkg::WCFG_W-1:0]       width,
	input  logic [despk_pkg::THR_W-1:0]        thresh,
	input  despk_pkg::q_stat_t                 q_stat,
	input  despk_pkg::cmd_t                    q_cmd,
	output logic                               pop,
	output despk_pkg::back_state_t             state,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [despk_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_row, out_col, out_level, glyph_code
	output logic                               m_tlast   // frame_end
);
	import despk_pkg::*;

	back_state_t      state_q;
	back_state_t      state_d;
	cmd_t             cur_q;
	logic [COL_W-1:0] fcol_q;
	logic [LVL_W-1:0] left_q;

	logic             m_tvalid_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [LVL_W-1:0] out_level_q;
	logic             out_end_q;

	logic             out_free;
	logic             exec_go;
	logic             fexec_go;
	logic             last_col;

	logic             rd_en;
	logic [COL_W-1:0] rd_col;
	logic [COL_W-1:0] rd_col_b;
	logic [LVL_W-1:0] orig_a;
	logic [LVL_W-1:0] orig_b;
	logic [LVL_W-1:0] upd_rd;

	logic             orig_we;
	logic             upd_we;
	logic [COL_W-1:0] col_sel;
	logic [3:0]       has;
	logic [LVL_W-1:0] down_lvl;
	logic [LVL_W-1:0] v;

	logic             out_load;
	logic [ROW_W-1:0] out_row_d;
	logic             out_end_d;

	assign state    = state_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign exec_go  = !cur_q.emit || out_free;
	assign fexec_go = out_free;
	assign last_col = ({1'b0, fcol_q} == width - WCFG_W'(1));
	assign rd_col_b = rd_col + COL_W'(1);
	assign col_sel  = (state_q == B_FEXEC) ? fcol_q : cur_q.col;

	always_comb begin
		has[NB_UP]    = (state_q == B_FEXEC) ? 1'b1 : (cur_q.row > ROW_W'(1));
		has[NB_DOWN]  = (state_q != B_FEXEC);
		has[NB_LEFT]  = (col_sel != '0);
		has[NB_RIGHT] = (({1'b0, col_sel} + WCFG_W'(1)) < width);
		down_lvl      = cur_q.lvl;
		v = despeckle(orig_a, upd_rd, down_lvl, left_q, orig_b, has, thresh);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_stat.empty)
					state_d = B_EXEC;
			end
			B_EXEC: begin
				if (exec_go)
					state_d = cur_q.last ? B_FREAD : B_IDLE;
			end
			B_FREAD: state_d = B_FEXEC;
			B_FEXEC: begin
				if (fexec_go)
					state_d = last_col ? B_IDLE : B_FREAD;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		rd_en     = 1'b0;
		rd_col    = fcol_q;
		orig_we   = 1'b0;
		upd_we    = 1'b0;
		out_load  = 1'b0;
		out_row_d = cur_q.row;
		out_end_d = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop    = !q_stat.empty;
				rd_en  = !q_stat.empty;
				rd_col = q_cmd.col;
			end
			B_EXEC: begin
				orig_we   = exec_go;
				upd_we    = exec_go && cur_q.emit;
				out_load  = exec_go && cur_q.emit;
				out_row_d = cur_q.row - ROW_W'(1);
			end
			B_FREAD: begin
				rd_en  = 1'b1;
				rd_col = fcol_q;
			end
			B_FEXEC: begin
				upd_we    = fexec_go;
				out_load  = fexec_go;
				out_end_d = last_col;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	despk_ram #(.WIDTH(LVL_W), .DEPTH(MAX_WIDTH)) u_orig_center (
		.clk   (clk),
		.we    (orig_we),
		.waddr (cur_q.col),
		.wdata (cur_q.lvl),
		.re    (rd_en),
		.raddr (rd_col),
		.rdata (orig_a)
	);

	despk_ram #(.WIDTH(LVL_W), .DEPTH(MAX_WIDTH)) u_orig_right (
		.clk   (clk),
		.we    (orig_we),
		.waddr (cur_q.col),
		.wdata (cur_q.lvl),
		.re    (rd_en),
		.raddr (rd_col_b),
		.rdata (orig_b)
	);

	despk_ram #(.WIDTH(LVL_W), .DEPTH(MAX_WIDTH)) u_updated (
		.clk   (clk),
		.we    (upd_we),
		.waddr (col_sel),
		.wdata (v),
		.re    (rd_en),
		.raddr (rd_col),
		.rdata (upd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_IDLE;
			fcol_q     <= '0;
			left_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (upd_we)
				left_q <= v;
			if (state_q == B_EXEC && exec_go && cur_q.last)
				fcol_q <= '0;
			else if (state_q == B_FEXEC && fexec_go)
				fcol_q <= fcol_q + COL_W'(1);
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= q_cmd;
		if (out_load) begin
			out_row_q   <= out_row_d;
			out_col_q   <= col_sel;
			out_level_q <= v;
			out_end_q   <= out_end_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_end_q;
	assign m_tdata  = {(OUT_DATA_W - ROW_W - COL_W - LVL_W - GLYPH_W)'(0),
		glyph_of(out_level_q), out_level_q, out_col_q, out_row_q};

endmodule

// ===== hdl/impulse_despeckle_filter.sv =====
// top level of the four-neighbor impulse despeckle filter
// depends on despk_pkg, despk_front, despk_queue, despk_back, assert_macros.svh
`timescale 1ns / 1ps
// Pixels enter on the s_ stream in raster order, one level in s_tdata[3:0]
// (values above 9 read as 9). Filtered pixels leave on the m_ stream with
// row, column, level and glyph in m_tdata and frame_end on m_tlast.
// Pixel (r,c) leaves once pixel (r+1,c) is taken; the frame's final pixel
// also releases its whole last row, with m_tlast on the last column.
// The cfg channel writes frame width, height and threshold (index 0..2);
// cfg_ready is always high and writes are meant for an idle block.
// The front end takes one pixel per cycle into a two-entry queue while it is not
// full. The back end handles each pixel as a line-buffer read, then filter and
// write, and pops the next pixel only once that is done; the last-row flush
// reads, filters and writes each column of the last row in turn. The filter
// step of a pixel loads the result of the pixel above into the output register.
// A stalled m_tready holds the output register; the back end then waits and
// the queue fills, after which s_tready drops.
// Reset loads the default registers (30 x 20, threshold 1) and restarts at
// row 0, column 0; the line buffers need no clearing.

module impulse_despeckle_filter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [despk_pkg::IN_DATA_W-1:0]     s_tdata,   // pixel_level
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [despk_pkg::OUT_DATA_W-1:0]    m_tdata,   // out_row, out_col, out_level, glyph_code
	output logic                                m_tlast,   // frame_end
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [despk_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [despk_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import despk_pkg::*;

`include "assert_macros.svh"

	logic [WCFG_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic [THR_W-1:0]  thresh_q;
	logic [WCFG_W-1:0] width_c;
	logic [ROW_W-1:0]  height_c;

	logic              push;
	cmd_t              push_cmd;
	cmd_t              head_cmd;
	q_stat_t           q_stat;
	logic [QPTR_W:0]   q_count;
	logic              pop;
	back_state_t       back_state;

	assign cfg_ready = 1'b1;
	assign width_c   = clamp_width(width_q);
	assign height_c  = clamp_height(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[WCFG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				CFG_THRESH: thresh_q <= cfg_data[THR_W-1:0];
				default:    ;
			endcase
		end
	end

	despk_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.width    (width_c),
		.height   (height_c),
		.q_stat   (q_stat),
		.push     (push),
		.cmd      (push_cmd)
	);

	despk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.stat     (q_stat),
		.count    (q_count)
	);

	despk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.width    (width_c),
		.thresh   (thresh_q),
		.q_stat   (q_stat),
		.q_cmd    (head_cmd),
		.pop      (pop),
		.state    (back_state),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	`ASSERT_ALWAYS(a_queue_bound, clk, arst_n, q_count <= (QPTR_W+1)'(QDEPTH))
	`ASSERT_IMPLIES(a_pop_only_idle, clk, arst_n, pop, back_state == B_IDLE && !q_stat.empty)
	`ASSERT_IMPLIES(a_level_range, clk, arst_n, m_tvalid, m_tdata[18:15] <= MAX_LEVEL)

endmodule
